// File: design/gb_pkg.sv
// shared types, constants and helpers for the 5x5 gaussian blur
package gb_pkg;

  localparam int PIX_W      = 32;
  localparam int RGB_W      = 24;
  localparam int NTAP       = 25;
  localparam int NGRP       = 6;
  localparam int WGT_W      = 16;
  localparam int GSUM_W     = 11;
  localparam int PROD_W     = 27;
  localparam int ACC_W      = 30;
  localparam int LINE_W     = 4 * RGB_W;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int QDEPTH     = 8;
  localparam int QAW        = 3;
  localparam int QCW        = 4;
  localparam int FLY_W      = 3;

  localparam int WIDTH_RESET  = 1024;
  localparam int HEIGHT_RESET = 768;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_W_CENTER = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_W_D8     = 4'd7;

  localparam logic [WGT_W-1:0] WGT_RESET [NGRP] = '{
    16'd3246, 16'd3070, 16'd2904, 16'd2599, 16'd2459, 16'd2081
  };

  typedef logic [RGB_W-1:0] rgb_t;
  typedef logic [NTAP-1:0][RGB_W-1:0] taps_t;

  typedef struct packed {
    logic pix;
    logic emit;
    logic border;
    logic fend;
  } job_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       fend;
  } res_t;

  // weight group of a tap by squared distance from the center
  function automatic logic [2:0] tap_group(input int k);
    int di;
    int dj;
    int dsq;
    logic [2:0] g;
    di  = k / 5 - 2;
    dj  = k % 5 - 2;
    dsq = di * di + dj * dj;
    case (dsq)
      0:       g = 3'd0;
      1:       g = 3'd1;
      2:       g = 3'd2;
      4:       g = 3'd3;
      5:       g = 3'd4;
      default: g = 3'd5;
    endcase
    return g;
  endfunction

endpackage

// File: design/gb_front.sv
// front end: accept, frame position tracking, pending pixel queue, classification
module gb_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [gb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gb_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic                             in_mode,
  input  logic [7:0]                       in_red_in,
  input  logic [7:0]                       in_green_in,
  input  logic [7:0]                       in_blue_in,
  input  logic [7:0]                       in_alpha_in,
  output logic                             lrd_en,
  output logic [CW-1:0]                    lrd_addr,
  output gb_pkg::job_t                     s1_job_r,
  output logic [CW-1:0]                    s1_col_r,
  output gb_pkg::rgb_t                     s1_rgb_r,
  output logic [gb_pkg::PIX_W-1:0]         s1_center_r
);

  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int HW     = $clog2(MAX_HEIGHT + 1);
  localparam int RW     = $clog2(MAX_HEIGHT);
  localparam int WX     = WW + 1;
  localparam int HX     = HW + 1;
  localparam int PDEPTH = 2 * MAX_WIDTH + 4;
  localparam int PAW    = $clog2(PDEPTH);
  localparam int W_RST  = (gb_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : gb_pkg::WIDTH_RESET;
  localparam int H_RST  = (gb_pkg::HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT
                                                                 : gb_pkg::HEIGHT_RESET;

  logic [WW-1:0]  w_eff_r;
  logic [HW-1:0]  h_eff_r;
  logic [CW-1:0]  col_r;
  logic [RW-1:0]  row_r;
  logic [CW-1:0]  ocol_r;
  logic [RW-1:0]  orow_r;
  logic [PAW-1:0] pcnt_r;
  logic [PAW-1:0] pcnt_nxt;
  logic [PAW-1:0] wptr_r;
  logic [PAW-1:0] rptr_r;
  logic [gb_pkg::PIX_W-1:0] pmem [PDEPTH];

  logic [10:0]    wv;
  logic [12:0]    hv;
  logic [WW-1:0]  w_clamp;
  logic [HW-1:0]  h_clamp;
  logic           geo_wr;
  logic           accept;
  logic           pix_acc;
  logic           fl_acc;
  logic           emit;
  logic [PAW-1:0] thr;
  logic           last_col;
  logic           last_row;
  logic           olast_col;
  logic           olast_row;
  logic           border;
  gb_pkg::job_t   s1_job_nxt;

  assign wv = cfg_wdata[10:0];
  assign hv = cfg_wdata[12:0];

  always_comb begin
    if (wv == '0) begin
      w_clamp = WW'(1);
    end else if (int'(wv) > MAX_WIDTH) begin
      w_clamp = WW'(MAX_WIDTH);
    end else begin
      w_clamp = WW'(wv);
    end
    if (hv == '0) begin
      h_clamp = HW'(1);
    end else if (int'(hv) > MAX_HEIGHT) begin
      h_clamp = HW'(MAX_HEIGHT);
    end else begin
      h_clamp = HW'(hv);
    end
  end

  assign geo_wr  = cfg_we && (cfg_index == gb_pkg::REG_WIDTH || cfg_index == gb_pkg::REG_HEIGHT);
  assign accept  = in_valid && !in_stall;
  assign pix_acc = accept && !in_mode;
  assign fl_acc  = accept && in_mode && col_r == '0 && row_r == '0 && pcnt_r != '0;
  assign thr     = PAW'({w_eff_r, 1'b0}) + PAW'(2);
  assign emit    = (pix_acc && pcnt_r >= thr) || fl_acc;

  assign last_col  = WW'(col_r) == w_eff_r - WW'(1);
  assign last_row  = HW'(row_r) == h_eff_r - HW'(1);
  assign olast_col = WW'(ocol_r) == w_eff_r - WW'(1);
  assign olast_row = HW'(orow_r) == h_eff_r - HW'(1);

  assign border = orow_r < RW'(2) || ocol_r < CW'(2)
               || HX'(orow_r) + HX'(2) >= HX'(h_eff_r)
               || WX'(ocol_r) + WX'(2) >= WX'(w_eff_r);

  always_comb begin
    pcnt_nxt = pcnt_r;
    if (pix_acc && !emit) begin
      pcnt_nxt = pcnt_r + PAW'(1);
    end else if (emit && !pix_acc) begin
      pcnt_nxt = pcnt_r - PAW'(1);
    end
    s1_job_nxt.pix    = pix_acc;
    s1_job_nxt.emit   = emit;
    s1_job_nxt.border = border;
    s1_job_nxt.fend   = olast_col && olast_row;
  end

  assign lrd_en   = pix_acc;
  assign lrd_addr = col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_eff_r  <= WW'(W_RST);
      h_eff_r  <= HW'(H_RST);
      col_r    <= '0;
      row_r    <= '0;
      ocol_r   <= '0;
      orow_r   <= '0;
      pcnt_r   <= '0;
      wptr_r   <= '0;
      rptr_r   <= '0;
      s1_job_r <= '0;
    end else begin
      if (cfg_we && cfg_index == gb_pkg::REG_WIDTH) begin
        w_eff_r <= w_clamp;
      end
      if (cfg_we && cfg_index == gb_pkg::REG_HEIGHT) begin
        h_eff_r <= h_clamp;
      end
      if (geo_wr) begin
        col_r  <= '0;
        row_r  <= '0;
        ocol_r <= '0;
        orow_r <= '0;
        pcnt_r <= '0;
        wptr_r <= '0;
        rptr_r <= '0;
      end else begin
        if (pix_acc) begin
          col_r  <= last_col ? '0 : col_r + CW'(1);
          if (last_col) begin
            row_r <= last_row ? '0 : row_r + RW'(1);
          end
          wptr_r <= (wptr_r == PAW'(PDEPTH - 1)) ? '0 : wptr_r + PAW'(1);
        end
        if (emit) begin
          ocol_r <= olast_col ? '0 : ocol_r + CW'(1);
          if (olast_col) begin
            orow_r <= olast_row ? '0 : orow_r + RW'(1);
          end
          rptr_r <= (rptr_r == PAW'(PDEPTH - 1)) ? '0 : rptr_r + PAW'(1);
        end
        pcnt_r <= pcnt_nxt;
      end
      s1_job_r <= s1_job_nxt;
    end
  end

  // pending pixel store, oldest entry is the next center
  always_ff @(posedge clk) begin
    if (pix_acc) begin
      pmem[wptr_r] <= {in_alpha_in, in_blue_in, in_green_in, in_red_in};
      s1_col_r     <= col_r;
      s1_rgb_r     <= {in_blue_in, in_green_in, in_red_in};
    end
    if (emit) begin
      s1_center_r <= pmem[rptr_r];
    end
  end

endmodule

// File: design/gb_window.sv
// line stores and the 5x5 tap window
module gb_window #(
  parameter int MAX_WIDTH = 1024,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     lrd_en,
  input  logic [CW-1:0]            lrd_addr,
  input  gb_pkg::job_t             s1_job,
  input  logic [CW-1:0]            s1_col,
  input  gb_pkg::rgb_t             s1_rgb,
  input  logic [gb_pkg::PIX_W-1:0] s1_center,
  output gb_pkg::job_t             s2_job_r,
  output logic [gb_pkg::PIX_W-1:0] s2_center_r,
  output gb_pkg::taps_t            taps_r
);

  localparam int RGB_W = gb_pkg::RGB_W;

  logic [gb_pkg::LINE_W-1:0] lmem [MAX_WIDTH];
  logic [gb_pkg::LINE_W-1:0] lrd_r;
  gb_pkg::rgb_t              newcol [5];
  gb_pkg::taps_t             taps_nxt;

  // one word per column holds the four previous rows, newest in the low bits
  always_ff @(posedge clk) begin
    if (lrd_en) begin
      lrd_r <= lmem[lrd_addr];
    end
    if (s1_job.pix) begin
      lmem[s1_col] <= {lrd_r[3*RGB_W-1:0], s1_rgb};
    end
  end

  always_comb begin
    newcol[4] = s1_rgb;
    newcol[3] = lrd_r[RGB_W-1:0];
    newcol[2] = lrd_r[2*RGB_W-1:RGB_W];
    newcol[1] = lrd_r[3*RGB_W-1:2*RGB_W];
    newcol[0] = lrd_r[4*RGB_W-1:3*RGB_W];
    for (int r = 0; r < 5; r++) begin
      for (int c = 0; c < 4; c++) begin
        taps_nxt[r*5+c] = taps_r[r*5+c+1];
      end
      taps_nxt[r*5+4] = newcol[r];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_job.pix) begin
      taps_r <= taps_nxt;
    end
    s2_center_r <= s1_center;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_job_r <= '0;
    end else begin
      s2_job_r <= s1_job;
    end
  end

endmodule

// File: design/gb_mac.sv
// weight registers and the three-stage weighted sum per color channel
module gb_mac (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [gb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gb_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  gb_pkg::job_t                  s2_job,
  input  logic [gb_pkg::PIX_W-1:0]      s2_center,
  input  gb_pkg::taps_t                 taps,
  output logic                          res_valid,
  output gb_pkg::res_t                  res,
  output logic [1:0]                    emits
);

  localparam int NGRP   = gb_pkg::NGRP;
  localparam int GSUM_W = gb_pkg::GSUM_W;
  localparam int PROD_W = gb_pkg::PROD_W;
  localparam int ACC_W  = gb_pkg::ACC_W;

  logic [gb_pkg::WGT_W-1:0] wgt_r [NGRP];
  logic [GSUM_W-1:0] gs [3][NGRP];
  logic [GSUM_W-1:0] gs_r [3][NGRP];
  logic [PROD_W-1:0] prod_r [3][NGRP];
  logic [ACC_W-1:0]  acc [3];
  logic [7:0]        val [3];
  gb_pkg::job_t      s3_job_r;
  gb_pkg::job_t      s4_job_r;
  logic [gb_pkg::PIX_W-1:0] s3_center_r;
  logic [gb_pkg::PIX_W-1:0] s4_center_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int g = 0; g < NGRP; g++) begin
        wgt_r[g] <= gb_pkg::WGT_RESET[g];
      end
    end else if (cfg_we && cfg_index >= gb_pkg::REG_W_CENTER
                 && cfg_index <= gb_pkg::REG_W_D8) begin
      wgt_r[3'(cfg_index - gb_pkg::REG_W_CENTER)] <= cfg_wdata;
    end
  end

  // taps of equal weight are added first
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int g = 0; g < NGRP; g++) begin
        gs[ch][g] = '0;
      end
    end
    for (int k = 0; k < gb_pkg::NTAP; k++) begin
      for (int ch = 0; ch < 3; ch++) begin
        gs[ch][gb_pkg::tap_group(k)] = gs[ch][gb_pkg::tap_group(k)]
                                     + GSUM_W'(taps[k][8*ch +: 8]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int g = 0; g < NGRP; g++) begin
        gs_r[ch][g]   <= gs[ch][g];
        prod_r[ch][g] <= PROD_W'(gs_r[ch][g]) * PROD_W'(wgt_r[g]);
      end
    end
    s3_center_r <= s2_center;
    s4_center_r <= s3_center_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_job_r <= '0;
      s4_job_r <= '0;
    end else begin
      s3_job_r <= s2_job;
      s4_job_r <= s3_job_r;
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      acc[ch] = '0;
      for (int g = 0; g < NGRP; g++) begin
        acc[ch] = acc[ch] + ACC_W'(prod_r[ch][g]);
      end
      val[ch] = (|acc[ch][ACC_W-1:24]) ? 8'd255 : acc[ch][23:16];
    end
    res.red   = s4_job_r.border ? s4_center_r[7:0]   : val[0];
    res.green = s4_job_r.border ? s4_center_r[15:8]  : val[1];
    res.blue  = s4_job_r.border ? s4_center_r[23:16] : val[2];
    res.alpha = s4_center_r[31:24];
    res.fend  = s4_job_r.fend;
  end

  assign res_valid = s4_job_r.emit;
  assign emits     = 2'(s3_job_r.emit) + 2'(s4_job_r.emit);

endmodule

// File: design/gb_queue.sv
// result queue between the arithmetic pipeline and the output channel
module gb_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  gb_pkg::res_t            din,
  input  logic                    pop,
  output gb_pkg::res_t            dout,
  output logic                    not_empty,
  output logic [gb_pkg::QCW-1:0]  cnt_r
);

  localparam int QAW = gb_pkg::QAW;

  gb_pkg::res_t   mem [gb_pkg::QDEPTH];
  logic [QAW-1:0] wptr_r;
  logic [QAW-1:0] rptr_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + QAW'(1);
      end
      if (pop) begin
        rptr_r <= rptr_r + QAW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + gb_pkg::QCW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - gb_pkg::QCW'(1);
      end
    end
  end

  assign dout      = mem[rptr_r];
  assign not_empty = cnt_r != '0;

endmodule

// File: design/gaussian_blur_5x5_rgba.sv
// 5x5 gaussian blur over a raster rgba pixel stream, top level
// throughput: one item per cycle while the output side keeps up
// path: a transfer's job passes stage registers s1 to s4, then the result
//   queue; in the stream, output lags input by two rows plus two pixels
// reset: synchronous active-low, clears positions, weights, job flags and
//   queue pointers; line stores are not cleared and need no clearing pass
module gaussian_blur_5x5_rgba #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [gb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gb_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_mode,
  input  logic [7:0]                    in_red_in,
  input  logic [7:0]                    in_green_in,
  input  logic [7:0]                    in_blue_in,
  input  logic [7:0]                    in_alpha_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_red_out,
  output logic [7:0]                    out_green_out,
  output logic [7:0]                    out_blue_out,
  output logic [7:0]                    out_alpha_out,
  output logic                          out_frame_end
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int FLY_W = gb_pkg::FLY_W;
  localparam int TOT_W = gb_pkg::QCW + 1;

  // front to window: line store read and stage one job
  logic                     lrd_en;
  logic [CW-1:0]            lrd_addr;
  gb_pkg::job_t             s1_job;
  logic [CW-1:0]            s1_col;
  gb_pkg::rgb_t             s1_rgb;
  logic [gb_pkg::PIX_W-1:0] s1_center;

  // window to arithmetic
  gb_pkg::job_t             s2_job;
  logic [gb_pkg::PIX_W-1:0] s2_center;
  gb_pkg::taps_t            taps;

  // arithmetic to result queue
  logic                     res_valid;
  gb_pkg::res_t             res;
  logic [1:0]               mac_emits;

  gb_pkg::res_t             q_dout;
  logic [gb_pkg::QCW-1:0]   q_cnt;
  logic                     out_xfer;
  logic [FLY_W-1:0]         in_flight;
  logic [TOT_W-1:0]         committed;

  // classification: pixel or flush, whether it causes a result, border and
  // frame end flags, and the oldest pending pixel as the center
  gb_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_mode     (in_mode),
    .in_red_in   (in_red_in),
    .in_green_in (in_green_in),
    .in_blue_in  (in_blue_in),
    .in_alpha_in (in_alpha_in),
    .lrd_en      (lrd_en),
    .lrd_addr    (lrd_addr),
    .s1_job_r    (s1_job),
    .s1_col_r    (s1_col),
    .s1_rgb_r    (s1_rgb),
    .s1_center_r (s1_center)
  );

  // four line stores and the sliding 5x5 window, shifted on pixel items only
  gb_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .lrd_en      (lrd_en),
    .lrd_addr    (lrd_addr),
    .s1_job      (s1_job),
    .s1_col      (s1_col),
    .s1_rgb      (s1_rgb),
    .s1_center   (s1_center),
    .s2_job_r    (s2_job),
    .s2_center_r (s2_center),
    .taps_r      (taps)
  );

  // group sums, products, final sum with truncation and saturation
  gb_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s2_job    (s2_job),
    .s2_center (s2_center),
    .taps      (taps),
    .res_valid (res_valid),
    .res       (res),
    .emits     (mac_emits)
  );

  assign out_xfer = out_valid && !out_stall;

  gb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .din       (res),
    .pop       (out_xfer),
    .dout      (q_dout),
    .not_empty (out_valid),
    .cnt_r     (q_cnt)
  );

  // credit check: the pipeline never stalls, so every result already on its
  // way must find a queue slot; stall the input once they could fill it
  assign in_flight = FLY_W'(s1_job.emit) + FLY_W'(s2_job.emit) + FLY_W'(mac_emits);
  assign committed = TOT_W'(q_cnt) + TOT_W'(in_flight);
  assign in_stall  = committed >= TOT_W'(gb_pkg::QDEPTH);

  assign out_red_out   = q_dout.red;
  assign out_green_out = q_dout.green;
  assign out_blue_out  = q_dout.blue;
  assign out_alpha_out = q_dout.alpha;
  assign out_frame_end = q_dout.fend;

`ifndef NO_ASSERTIONS
  // results in the queue plus those in the pipeline never exceed its depth
  a_credit: assert property (@(posedge clk) disable iff (!rst_n)
    committed <= TOT_W'(gb_pkg::QDEPTH))
    else $error("result credit exceeded");

  // a result never arrives at a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> q_cnt != gb_pkg::QCW'(gb_pkg::QDEPTH))
    else $error("result queue overflow");

  // nothing is offered right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");
`endif

endmodule
